@@ rtl/ubd_pkg.sv @@
// Shared widths, constants and types for the baud divisor unit.
`default_nettype none
package ubd_pkg;

   localparam int BAUD_W   = 24;
   localparam int CLK_W    = 28;
   localparam int QUOT_W   = 33;
   localparam int REM_W    = 26;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 2;
   localparam int MANT_W   = 12;
   localparam int FRAC_W   = 4;
   localparam int LOW_W    = 19;
   localparam int REM100_W = 7;
   localparam int TERM_W   = 11;

   localparam logic [CLK_W-1:0]  CLOCK_RESET_HZ = CLK_W'(16000000);
   localparam logic [QUOT_W-1:0] CLOCK_SCALE    = QUOT_W'(25);

   // scaled divisor at or above this gives a mantissa over 12 bits
   localparam logic [QUOT_W-1:0] SAT_LIMIT = QUOT_W'(409600);

   // reciprocal of 100, exact for values below SAT_LIMIT
   localparam int                RECIP_MANT_W     = 20;
   localparam logic [RECIP_MANT_W-1:0] RECIP_MANT = RECIP_MANT_W'(671089);
   localparam int                RECIP_MANT_SHIFT = 26;

   // reciprocal of 100, exact for the rounding term range
   localparam int                RECIP_FRAC_W     = 12;
   localparam logic [RECIP_FRAC_W-1:0] RECIP_FRAC = RECIP_FRAC_W'(2622);
   localparam int                RECIP_FRAC_SHIFT = 18;

   localparam logic [REM100_W-1:0] HUNDRED    = REM100_W'(100);
   localparam logic [TERM_W-1:0]   ROUND_BIAS = TERM_W'(50);

   localparam logic [FRAC_W-1:0] FRAC_MASK_8  = FRAC_W'(4'h7);
   localparam logic [FRAC_W-1:0] FRAC_MASK_16 = FRAC_W'(4'hF);
   localparam logic [MANT_W-1:0] MANT_MAX     = MANT_W'(4095);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAUD_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

   // one request in flight through the divider chain
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] work;
      logic [REM_W-1:0]  divisor;
      logic              over8;
      logic              zero;
   } ubd_div_type;

endpackage
`default_nettype wire

@@ rtl/ubd_if.sv @@
// Request, response and register write channels of the baud divisor unit.
`default_nettype none
interface ubd_req_if;
   import ubd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BAUD_W-1:0] baud_rate;
   logic              oversample_by_8;
   modport source (output valid, baud_rate, oversample_by_8, input ready);
   modport sink   (input valid, baud_rate, oversample_by_8, output ready);
endinterface

interface ubd_rsp_if;
   import ubd_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   divisor_word;
   logic [STATUS_W-1:0] status;
   modport source (output valid, divisor_word, status, input ready);
   modport sink   (input valid, divisor_word, status, output ready);
endinterface

interface ubd_csr_if;
   import ubd_pkg::*;
   logic             valid;
   logic             ready;
   logic [CLK_W-1:0] clock_hz;
   modport source (output valid, clock_hz, input ready);
   modport sink   (input valid, clock_hz, output ready);
endinterface
`default_nettype wire

@@ rtl/uart_baud_divisor_unit.sv @@
// Top level of the UART baud divisor unit: clock register, divider chain, post stages.
//
//  channel   direction  handshake      payload
//  req_ch    in         valid/ready    baud_rate[23:0], oversample_by_8
//  rsp_ch    out        valid/ready    divisor_word[15:0], status[1:0]
//  csr_ch    in         valid/ready    clock_hz[27:0]
//
// One request per cycle is accepted while the response channel is not stalled; each passes
// through 33 division cells, one quotient bit each, then three stages for the mantissa,
// the rounded fraction and the output register.
// Reset clears the stage valid bits and loads clock_hz with 16000000.
// Every stage advances when it is empty or the stage after it moves, so a stalled
// response only holds back stages that are full; bubbles still fill.
`default_nettype none
module uart_baud_divisor_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   ubd_req_if.sink    req_ch,
   ubd_rsp_if.source  rsp_ch,
   ubd_csr_if.sink    csr_ch
);
   import ubd_pkg::*;

   logic [CLK_W-1:0] clock_hz_ff;
   logic [CLK_W-1:0] clock_hz_in;

   logic        stage_valid [0:QUOT_W];
   logic        stage_ready [0:QUOT_W];
   ubd_div_type stage_data  [0:QUOT_W];
   ubd_div_type load_data;

   assign csr_ch.ready = 1'b1;
   assign clock_hz_in  = csr_ch.valid ? csr_ch.clock_hz : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET_HZ;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   // load the dividend 25*clock and the divisor 2*baud or 4*baud
   always_comb begin
      load_data.rem  = '0;
      load_data.work = QUOT_W'(clock_hz_ff) * CLOCK_SCALE;
      if (req_ch.oversample_by_8) begin
         load_data.divisor = REM_W'(req_ch.baud_rate) << 1;
      end else begin
         load_data.divisor = REM_W'(req_ch.baud_rate) << 2;
      end
      load_data.over8 = req_ch.oversample_by_8;
      load_data.zero  = (req_ch.baud_rate == '0);
   end

   assign stage_data[0]  = load_data;
   assign stage_valid[0] = req_ch.valid;
   assign req_ch.ready   = stage_ready[0];

   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      ubd_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stage_valid[i]),
         .up_ready   (stage_ready[i]),
         .up_data    (stage_data[i]),
         .down_valid (stage_valid[i+1]),
         .down_ready (stage_ready[i+1]),
         .down_data  (stage_data[i+1])
      );
   end

   ubd_post u_post (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (stage_valid[QUOT_W]),
      .up_ready    (stage_ready[QUOT_W]),
      .up_data     (stage_data[QUOT_W]),
      .down_valid  (rsp_ch.valid),
      .down_ready  (rsp_ch.ready),
      .down_word   (rsp_ch.divisor_word),
      .down_status (rsp_ch.status)
   );
endmodule
`default_nettype wire

@@ rtl/ubd_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per request.
`default_nettype none
module ubd_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire ubd_pkg::ubd_div_type up_data,
   output logic                     down_valid,
   input  wire logic                down_ready,
   output ubd_pkg::ubd_div_type     down_data
);
   import ubd_pkg::*;

   logic              valid_ff;
   ubd_div_type       data_ff;
   ubd_div_type       data_in;
   logic [REM_W:0]    shifted;
   logic [REM_W+1:0]  diff;
   logic              ge;

   always_comb begin
      shifted = {up_data.rem, up_data.work[QUOT_W-1]};
      diff    = {1'b0, shifted} - {2'b00, up_data.divisor};
      ge      = ~diff[REM_W+1];
      data_in = up_data;
      data_in.rem  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      data_in.work = {up_data.work[QUOT_W-2:0], ge};
   end

   // advance when this slot is empty or its contents move on
   assign up_ready = ~valid_ff | down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
endmodule
`default_nettype wire

@@ rtl/ubd_post.sv @@
// Split the scaled divisor into mantissa and rounded fraction, pack the word.
`default_nettype none
module ubd_post (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      up_valid,
   output logic                           up_ready,
   input  wire ubd_pkg::ubd_div_type      up_data,
   output logic                           down_valid,
   input  wire logic                      down_ready,
   output logic [ubd_pkg::WORD_W-1:0]     down_word,
   output logic [ubd_pkg::STATUS_W-1:0]   down_status
);
   import ubd_pkg::*;

   localparam int MANT_PROD_W = RECIP_MANT_W + LOW_W;
   localparam int FRAC_PROD_W = RECIP_FRAC_W + TERM_W;

   // stage 1: saturation check and mantissa by reciprocal
   logic                 v1_ff;
   logic                 adv1;
   logic [LOW_W-1:0]     low1_ff;
   logic [MANT_W-1:0]    mant1_ff;
   logic                 sat1_ff, zero1_ff, over81_ff;
   logic [MANT_PROD_W-1:0] mant_prod;

   // stage 2: hundredths remainder and rounding term
   logic                 v2_ff;
   logic                 adv2;
   logic [MANT_W-1:0]    mant2_ff;
   logic [TERM_W-1:0]    term2_ff;
   logic                 sat2_ff, zero2_ff, over82_ff;
   logic [LOW_W-1:0]     hund_prod;
   logic [REM100_W-1:0]  rem100;
   logic [TERM_W-1:0]    term_in;

   // stage 3: fraction and packed word, output register
   logic                 v3_ff;
   logic                 adv3;
   logic [WORD_W-1:0]    word3_ff;
   logic [STATUS_W-1:0]  status3_ff;
   logic [FRAC_PROD_W-1:0] frac_prod;
   logic [FRAC_W-1:0]    fmask;
   logic [FRAC_W-1:0]    frac;
   logic [WORD_W-1:0]    word_in;
   logic [STATUS_W-1:0]  status_in;

   assign adv3 = ~v3_ff | down_ready;
   assign adv2 = ~v2_ff | adv3;
   assign adv1 = ~v1_ff | adv2;
   assign up_ready = adv1;

   assign mant_prod = MANT_PROD_W'(up_data.work[LOW_W-1:0]) * MANT_PROD_W'(RECIP_MANT);

   always_comb begin
      hund_prod = LOW_W'(mant1_ff) * LOW_W'(HUNDRED);
      rem100    = REM100_W'(low1_ff - hund_prod);
      if (over81_ff) begin
         term_in = (TERM_W'(rem100) << 3) + ROUND_BIAS;
      end else begin
         term_in = (TERM_W'(rem100) << 4) + ROUND_BIAS;
      end
   end

   always_comb begin
      frac_prod = FRAC_PROD_W'(term2_ff) * FRAC_PROD_W'(RECIP_FRAC);
      fmask     = over82_ff ? FRAC_MASK_8 : FRAC_MASK_16;
      frac      = frac_prod[RECIP_FRAC_SHIFT +: FRAC_W] & fmask;
      if (zero2_ff) begin
         word_in   = '0;
         status_in = STATUS_BAUD_ZERO;
      end else if (sat2_ff) begin
         word_in   = {MANT_MAX, fmask};
         status_in = STATUS_SATURATED;
      end else begin
         word_in   = {mant2_ff, frac};
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= up_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         low1_ff   <= up_data.work[LOW_W-1:0];
         mant1_ff  <= mant_prod[RECIP_MANT_SHIFT +: MANT_W];
         sat1_ff   <= (up_data.work >= SAT_LIMIT);
         zero1_ff  <= up_data.zero;
         over81_ff <= up_data.over8;
      end
      if (adv2) begin
         mant2_ff  <= mant1_ff;
         term2_ff  <= term_in;
         sat2_ff   <= sat1_ff;
         zero2_ff  <= zero1_ff;
         over82_ff <= over81_ff;
      end
      if (adv3) begin
         word3_ff   <= word_in;
         status3_ff <= status_in;
      end
   end

   assign down_valid  = v3_ff;
   assign down_word   = word3_ff;
   assign down_status = status3_ff;
endmodule
`default_nettype wire
